FILE: rtl/core/rtxo_pkg.sv
`default_nettype none
package rtxo_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CFG_IDX_W = 2;

	typedef logic [BYTE_W-1:0] byte_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STATIC_KEY  = 2'd0,
		REG_SESSION_KEY = 2'd1,
		REG_DIRECTION   = 2'd2
	} reg_idx_t;

	typedef enum logic {
		DIR_OBFUSCATE   = 1'b0,
		DIR_DEOBFUSCATE = 1'b1
	} dir_t;

	typedef struct packed {
		byte_t static_key;
		byte_t session_key;
		dir_t  direction;
	} cfg_t;

	// keystream byte of one pass
	function automatic byte_t mask_of(byte_t chain, byte_t key, byte_t pos);
		return byte_t'(chain + key + pos);
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/rtxo_if.sv
`default_nettype none
interface rtxo_msg_if;
	import rtxo_pkg::*;
	logic  valid;
	logic  ready;
	byte_t data_byte;
	logic  last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rtxo_res_if;
	import rtxo_pkg::*;
	logic  valid;
	logic  ready;
	byte_t out_byte;
	logic  out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink (input valid, input out_byte, input out_last, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/rtxo_cfg.sv
`default_nettype none
module rtxo_cfg
	import rtxo_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [BYTE_W-1:0]    cfg_data,
	output      cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{static_key: '0, session_key: '0, direction: DIR_OBFUSCATE};
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_STATIC_KEY:  cfg_q.static_key  <= cfg_data;
				REG_SESSION_KEY: cfg_q.session_key <= cfg_data;
				REG_DIRECTION:   cfg_q.direction   <= dir_t'(cfg_data[0]);
				default: ; // unmapped index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

FILE: rtl/core/rtxo_core.sv
`default_nettype none
module rtxo_core
	import rtxo_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cfg_t   cfg,
	rtxo_msg_if.sink    msg,
	rtxo_res_if.source  res
);

	// input register
	logic  vld_s1;
	byte_t data_s1;
	logic  last_s1;

	// output register
	logic  vld_q;
	byte_t out_byte_q;
	logic  out_last_q;

	// message state
	byte_t idx_q;
	byte_t chain1_q;
	byte_t chain2_q;

	logic  adv;
	byte_t pos;
	byte_t key1;
	byte_t key2;
	byte_t s1;
	byte_t s2;
	byte_t chain1_d;
	byte_t chain2_d;

	assign adv       = vld_s1 && (!vld_q || res.ready);
	assign msg.ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (msg.ready) begin
			vld_s1 <= msg.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (msg.valid && msg.ready) begin
			data_s1 <= msg.data_byte;
			last_s1 <= msg.last_byte;
		end
	end

	always_comb begin
		pos = byte_t'(idx_q + byte_t'(1));
		if (cfg.direction == DIR_OBFUSCATE) begin
			key1 = cfg.session_key;
			key2 = cfg.static_key;
		end else begin
			key1 = cfg.static_key;
			key2 = cfg.session_key;
		end
		s1 = data_s1 ^ mask_of(chain1_q, key1, pos);
		s2 = s1 ^ mask_of(chain2_q, key2, pos);
		// obfuscate chains on written bytes, deobfuscate on read bytes
		if (cfg.direction == DIR_OBFUSCATE) begin
			chain1_d = s1;
			chain2_d = s2;
		end else begin
			chain1_d = data_s1;
			chain2_d = s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			chain1_q <= '0;
			chain2_q <= '0;
		end else if (adv) begin
			if (last_s1) begin
				idx_q    <= '0;
				chain1_q <= '0;
				chain2_q <= '0;
			end else begin
				idx_q    <= pos;
				chain1_q <= chain1_d;
				chain2_q <= chain2_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (!vld_q || res.ready) begin
			vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q <= s2;
			out_last_q <= last_s1;
		end
	end

	assign res.valid    = vld_q;
	assign res.out_byte = out_byte_q;
	assign res.out_last = out_last_q;

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> idx_q == '0 && chain1_q == '0 && chain2_q == '0)
		else $error("state not cleared after last word");

	a_idx_steps: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !last_s1 |=> idx_q == byte_t'($past(idx_q) + byte_t'(1)))
		else $error("position did not advance by one");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(idx_q) && $stable(chain1_q) && $stable(chain2_q))
		else $error("message state changed without a word moving");

	a_obf_chain: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !last_s1 && cfg.direction == DIR_OBFUSCATE |=> chain2_q == out_byte_q)
		else $error("second chain does not track emitted word");

endmodule
`default_nettype wire

FILE: rtl/core/two_pass_rolling_xor_obfuscator_top.sv
`default_nettype none
// Two-pass rolling XOR obfuscator. Each message word on msg yields exactly one word
// on res, XORed by two chained passes keyed by the session key and the static key
// (order swapped by direction); a word with last_byte set restarts position and chains
// for the next message. One word per clock is sustained while res is ready: a word
// passes through the input register and then sits in the output register, and the
// chain update through two 8-bit adds and XORs is the feedback path between words.
// Registers (cfg_idx): 0 static key, 1 session key, 2 direction (0 obfuscate,
// 1 deobfuscate); index 3 is ignored. Write them only while no word is in flight;
// a change takes effect from the next word.
module two_pass_rolling_xor_obfuscator_top
	import rtxo_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [BYTE_W-1:0]    cfg_data,
	rtxo_msg_if.sink                  msg,
	rtxo_res_if.source                res
);

	cfg_t cfg;

	rtxo_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	rtxo_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.msg    (msg),
		.res    (res)
	);

endmodule
`default_nettype wire
